// ----- rtl/cdq_pkg.sv -----
`default_nettype none
package cdq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 8;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_REAR  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_REAR   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_R,
        CELL_SHIFT_L,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   push_data;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/cdq_cmd_if.sv -----
`default_nettype none
interface cdq_cmd_if
    import cdq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, output command, output data_in, input ready);
    modport sink   (input valid, input command, input data_in, output ready);
endinterface
`default_nettype wire

// ----- rtl/cdq_result_if.sv -----
`default_nettype none
interface cdq_result_if
    import cdq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, output data_out, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input data_out, input status, input occupancy,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/circular_deque.sv -----
// Byte-wide double-ended queue of DEPTH entries.
//
// Requests arrive on the cmd channel (command, data_in) and each one gives
// exactly one result request on the result channel (data_out, status,
// occupancy). Both channels use valid/ready; a transfer happens on a clock
// edge with both high.
//
// Storage is a row of cells with the front of the queue in cell 0. Push at
// front shifts the row right, pop at front shifts it left; a rear push loads
// the cell at the count, a rear pop reads the cell at count - 1. Every cell
// moves in the same cycle, so one request completes per cycle unless stalled.
//
// The result is registered and valid in the cycle after the request is
// taken. Throughput: one request per cycle while the result side keeps up;
// a new request is taken in the same cycle the held result is taken.
// When the receiver stalls, the held result stays and cmd.ready drops.
// Reset empties the queue (count zero); cell contents are not cleared and
// are never read before being written.
`default_nettype none
module circular_deque
    import cdq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    cdq_cmd_if.sink        cmd,
    cdq_result_if.source   result
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] data_out_reg;
    logic [DATA_W-1:0] data_out_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;

    logic              accept;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  count_m1;
    logic [IDX_W-1:0]  last_idx;

    cell_ctrl_t        ctrl [DEPTH];
    logic [DATA_W-1:0] cell_q [DEPTH];

    assign cmd.ready = !out_valid_reg || result.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign count_m1  = count_reg - 1'b1;
    assign last_idx  = count_m1[IDX_W-1:0];

    // per-cell control
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ctrl[i].op        = CELL_HOLD;
            ctrl[i].push_data = cmd.data_in;
            if (accept)
            begin
                case (cmd_t'(cmd.command))
                    CMD_PUSH_REAR:
                        if (!full && count_reg == CNT_W'(i))
                            ctrl[i].op = CELL_LOAD;
                    CMD_PUSH_FRONT:
                        if (!full)
                            ctrl[i].op = CELL_SHIFT_R;
                    CMD_POP_FRONT:
                        if (!empty)
                            ctrl[i].op = CELL_SHIFT_L;
                    default:
                        ctrl[i].op = CELL_HOLD;
                endcase
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = cmd.data_in;
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[g+1];
        end

        cdq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[g]),
            .left_data  (left_d),
            .right_data (right_d),
            .q          (cell_q[g])
        );
    end

    // result of the current request
    always_comb
    begin
        count_next    = count_reg;
        data_out_next = data_out_reg;
        status_next   = status_reg;
        occ_next      = occ_reg;
        if (accept)
        begin
            data_out_next = '0;
            status_next   = ST_OK;
            case (cmd_t'(cmd.command))
                CMD_PUSH_REAR, CMD_PUSH_FRONT:
                    if (full)
                        status_next = ST_OVERFLOW;
                    else
                        count_next = count_reg + 1'b1;
                CMD_POP_FRONT:
                    if (empty)
                        status_next = ST_UNDERFLOW;
                    else
                    begin
                        data_out_next = cell_q[0];
                        count_next    = count_m1;
                    end
                CMD_POP_REAR:
                    if (empty)
                        status_next = ST_UNDERFLOW;
                    else
                    begin
                        data_out_next = cell_q[last_idx];
                        count_next    = count_m1;
                    end
                default:
                    status_next = ST_OK;
            endcase
            occ_next = OCC_W'(count_next);
        end
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_out_reg <= data_out_next;
        status_reg   <= status_next;
        occ_reg      <= occ_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.data_out  = data_out_reg;
    assign result.status    = status_reg;
    assign result.occupancy = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count moved without a request");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("no result after request");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (data_out_reg == '0))
        else $error("rejected request returned data");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.command == CMD_PUSH_REAR || cmd.command == CMD_PUSH_FRONT)
         && full) |=> (count_reg == CNT_W'(DEPTH)))
        else $error("overflow changed count");

endmodule
`default_nettype wire

// ----- rtl/cdq_cell.sv -----
`default_nettype none
module cdq_cell
    import cdq_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic      [DATA_W-1:0] q
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        case (ctrl.op)
            CELL_SHIFT_R: data_next = left_data;
            CELL_SHIFT_L: data_next = right_data;
            CELL_LOAD:    data_next = ctrl.push_data;
            default:      data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule
`default_nettype wire
